### rtl/core/morse_character_keyer_defines.svh
// Assertion macros used by the keyer port checker
`ifndef MORSE_CHARACTER_KEYER_DEFINES_SVH
`define MORSE_CHARACTER_KEYER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define MCK_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define MCK_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/mck_pkg.sv
// Types, constants and the character lookup table for the Morse keyer
package mck_pkg;

	localparam int TICK_W = 16;
	localparam int IDX_W  = 3;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DOT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DASH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAP  = 2'd2;

	localparam logic [TICK_W-1:0] DOT_RESET  = 16'd200;
	localparam logic [TICK_W-1:0] DASH_RESET = 16'd600;
	localparam logic [TICK_W-1:0] GAP_RESET  = 16'd200;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef enum logic [1:0] {
		EL_NONE = 2'd0,
		EL_DOT  = 2'd1,
		EL_DASH = 2'd2
	} el_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_ON   = 2'd1,
		PH_GAP  = 2'd2
	} key_phase_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] char_code;
	} mck_in_t;

	typedef struct packed {
		logic led_on;
		logic busy_res;
		logic accepted;
		logic char_done;
	} mck_out_t;

	typedef struct packed {
		logic [TICK_W-1:0] dot_ticks;
		logic [TICK_W-1:0] dash_ticks;
		logic [TICK_W-1:0] gap_ticks;
	} mck_cfg_t;

	// Pattern: element count, then dashes left-justified (bit 5 is the first element)
	typedef struct packed {
		logic       known;
		logic [2:0] len;
		logic [5:0] dashes;
	} mck_pat_t;

	function automatic mck_pat_t pattern_of(input logic [7:0] c);
		mck_pat_t p;
		p = '{known: 1'b1, len: 3'd0, dashes: 6'b000000};
		unique case (c)
			"A": {p.len, p.dashes} = {3'd2, 6'b010000};
			"B": {p.len, p.dashes} = {3'd4, 6'b100000};
			"C": {p.len, p.dashes} = {3'd4, 6'b101000};
			"D": {p.len, p.dashes} = {3'd3, 6'b100000};
			"E": {p.len, p.dashes} = {3'd1, 6'b000000};
			"F": {p.len, p.dashes} = {3'd4, 6'b001000};
			"G": {p.len, p.dashes} = {3'd3, 6'b110000};
			"H": {p.len, p.dashes} = {3'd4, 6'b000000};
			"I": {p.len, p.dashes} = {3'd2, 6'b000000};
			"J": {p.len, p.dashes} = {3'd4, 6'b011100};
			"K": {p.len, p.dashes} = {3'd3, 6'b101000};
			"L": {p.len, p.dashes} = {3'd4, 6'b010000};
			"M": {p.len, p.dashes} = {3'd2, 6'b110000};
			"N": {p.len, p.dashes} = {3'd2, 6'b100000};
			"O": {p.len, p.dashes} = {3'd3, 6'b111000};
			"P": {p.len, p.dashes} = {3'd4, 6'b011000};
			"Q": {p.len, p.dashes} = {3'd4, 6'b110100};
			"R": {p.len, p.dashes} = {3'd3, 6'b010000};
			"S": {p.len, p.dashes} = {3'd3, 6'b000000};
			"T": {p.len, p.dashes} = {3'd1, 6'b100000};
			"U": {p.len, p.dashes} = {3'd3, 6'b001000};
			"V": {p.len, p.dashes} = {3'd4, 6'b000100};
			"W": {p.len, p.dashes} = {3'd3, 6'b011000};
			"X": {p.len, p.dashes} = {3'd4, 6'b100100};
			"Y": {p.len, p.dashes} = {3'd4, 6'b101100};
			"Z": {p.len, p.dashes} = {3'd4, 6'b110000};
			"0": {p.len, p.dashes} = {3'd5, 6'b111110};
			"1": {p.len, p.dashes} = {3'd5, 6'b011110};
			"2": {p.len, p.dashes} = {3'd5, 6'b001110};
			"3": {p.len, p.dashes} = {3'd5, 6'b000110};
			"4": {p.len, p.dashes} = {3'd5, 6'b000010};
			"5": {p.len, p.dashes} = {3'd5, 6'b000000};
			"6": {p.len, p.dashes} = {3'd5, 6'b100000};
			"7": {p.len, p.dashes} = {3'd5, 6'b110000};
			"8": {p.len, p.dashes} = {3'd5, 6'b111000};
			"9": {p.len, p.dashes} = {3'd5, 6'b111100};
			"?": {p.len, p.dashes} = {3'd6, 6'b001100};
			"/": {p.len, p.dashes} = {3'd5, 6'b100100};
			"(": {p.len, p.dashes} = {3'd5, 6'b101100};
			"-": {p.len, p.dashes} = {3'd6, 6'b100001};
			".": {p.len, p.dashes} = {3'd6, 6'b010101};
			default: p.known = 1'b0;
		endcase
		return p;
	endfunction

endpackage

### rtl/core/mck_core.sv
// Keying state and the per-item next-state logic
module mck_core #(
	parameter int MAX_ELEMENTS = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  mck_pkg::mck_in_t  item,
	input  mck_pkg::mck_cfg_t cfg,
	output mck_pkg::mck_out_t result
);

	localparam int SLOT_W = $clog2(MAX_ELEMENTS);

	mck_pkg::el_t                   codes_q [MAX_ELEMENTS];
	mck_pkg::el_t                   codes_d [MAX_ELEMENTS];
	logic [mck_pkg::IDX_W-1:0]      idx_q, idx_d, idx_inc;
	mck_pkg::key_phase_t            phase_q, phase_d;
	logic [mck_pkg::TICK_W-1:0]     cnt_q, cnt_d, cnt_inc, on_limit;
	logic                           led_q, led_d;
	logic                           acc, done;
	mck_pkg::mck_pat_t              pat;
	logic [7:0]                     dash_ext;
	mck_pkg::el_t                   cur_code, nxt_code;
	logic                           load, on_end, gap_end, more;

	assign pat      = mck_pkg::pattern_of(item.char_code);
	assign dash_ext = {pat.dashes, 2'b00};
	assign load     = (item.cmd == mck_pkg::CMD_LOAD) && (phase_q == mck_pkg::PH_IDLE)
		&& pat.known;

	assign cur_code = ({1'b0, idx_q} < 4'(MAX_ELEMENTS)) ? codes_q[idx_q[SLOT_W-1:0]]
		: mck_pkg::EL_NONE;
	assign idx_inc  = idx_q + 3'd1;
	assign nxt_code = ({1'b0, idx_inc} < 4'(MAX_ELEMENTS)) ? codes_q[idx_inc[SLOT_W-1:0]]
		: mck_pkg::EL_NONE;
	assign more     = (nxt_code != mck_pkg::EL_NONE);

	assign cnt_inc  = cnt_q + 16'd1;
	assign on_limit = (cur_code == mck_pkg::EL_DASH) ? cfg.dash_ticks : cfg.dot_ticks;
	assign on_end   = (cnt_inc >= on_limit);
	assign gap_end  = (cnt_inc >= cfg.gap_ticks);

	// Next phase
	always_comb begin
		phase_d = phase_q;
		if (item.cmd == mck_pkg::CMD_LOAD) begin
			if (load) begin
				phase_d = mck_pkg::PH_ON;
			end
		end else begin
			unique case (phase_q)
				mck_pkg::PH_ON: begin
					if (on_end) begin
						phase_d = mck_pkg::PH_GAP;
					end
				end
				mck_pkg::PH_GAP: begin
					if (gap_end) begin
						phase_d = more ? mck_pkg::PH_ON : mck_pkg::PH_IDLE;
					end
				end
				default: phase_d = phase_q;
			endcase
		end
	end

	// Datapath and flags
	always_comb begin
		codes_d = codes_q;
		idx_d   = idx_q;
		cnt_d   = cnt_q;
		led_d   = led_q;
		acc     = 1'b0;
		done    = 1'b0;
		if (item.cmd == mck_pkg::CMD_LOAD) begin
			if (load) begin
				for (int i = 0; i < MAX_ELEMENTS; i++) begin
					if (4'(i) < {1'b0, pat.len}) begin
						codes_d[i] = dash_ext[7-i] ? mck_pkg::EL_DASH : mck_pkg::EL_DOT;
					end else begin
						codes_d[i] = mck_pkg::EL_NONE;
					end
				end
				idx_d = '0;
				cnt_d = '0;
				led_d = 1'b1;
				acc   = 1'b1;
			end
		end else begin
			unique case (phase_q)
				mck_pkg::PH_ON: begin
					cnt_d = on_end ? '0 : cnt_inc;
					if (on_end) begin
						led_d = 1'b0;
					end
				end
				mck_pkg::PH_GAP: begin
					cnt_d = gap_end ? '0 : cnt_inc;
					if (gap_end) begin
						if (more) begin
							idx_d = idx_inc;
							led_d = 1'b1;
						end else begin
							// last gap: drop the pattern and go idle
							for (int i = 0; i < MAX_ELEMENTS; i++) begin
								codes_d[i] = mck_pkg::EL_NONE;
							end
							idx_d = '0;
							led_d = 1'b0;
							done  = 1'b1;
						end
					end
				end
				default: cnt_d = cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_ELEMENTS; i++) begin
				codes_q[i] <= mck_pkg::EL_NONE;
			end
			idx_q   <= '0;
			phase_q <= mck_pkg::PH_IDLE;
			cnt_q   <= '0;
			led_q   <= 1'b0;
		end else if (step) begin
			codes_q <= codes_d;
			idx_q   <= idx_d;
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			led_q   <= led_d;
		end
	end

	assign result.led_on    = led_d;
	assign result.busy_res  = (phase_d != mck_pkg::PH_IDLE);
	assign result.accepted  = acc;
	assign result.char_done = done;

endmodule

### rtl/core/morse_character_keyer.sv
// Morse keyer: one character or tick per item, one result per item, held in an output register.
// Each accepted item updates the keying state in the cycle it is accepted; its result
// sits in the output register from the next edge until taken.
// Throughput is one item per cycle; the input stalls only while the output register
// holds a result that is itself stalled.
// Reset clears the keying state to idle with the LED off and loads 200/600/200 ticks.
module morse_character_keyer #(
	parameter int MAX_ELEMENTS = 6
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  mck_pkg::mck_in_t                 req,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output mck_pkg::mck_out_t                rsp,
	input  logic                             cfg_we,
	input  logic [mck_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mck_pkg::TICK_W-1:0]       cfg_wdata
);

	mck_pkg::mck_cfg_t cfg_q;
	mck_pkg::mck_out_t result;
	mck_pkg::mck_out_t rsp_q;
	logic              rsp_valid_q;
	logic              accept;

	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dot_ticks  <= mck_pkg::DOT_RESET;
			cfg_q.dash_ticks <= mck_pkg::DASH_RESET;
			cfg_q.gap_ticks  <= mck_pkg::GAP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mck_pkg::REG_DOT:  cfg_q.dot_ticks  <= cfg_wdata;
				mck_pkg::REG_DASH: cfg_q.dash_ticks <= cfg_wdata;
				mck_pkg::REG_GAP:  cfg_q.gap_ticks  <= cfg_wdata;
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	mck_core #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (accept),
		.item   (req),
		.cfg    (cfg_q),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Payload holds while stalled, loads on every accepted item
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### rtl/core/mck_checker.sv
// Port-level checks for the Morse keyer, bound to the top level
`include "morse_character_keyer_defines.svh"

module mck_port_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_stall,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input mck_pkg::mck_out_t rsp
);

	`MCK_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp),
		"result item changed while stalled")
	`MCK_ASSERT_IMP(a_stall_only_full, req_stall, rsp_valid && rsp_stall,
		"input stalled with output free")
	`MCK_ASSERT_IMP(a_accept_keys, rsp_valid && rsp.accepted,
		rsp.busy_res && rsp.led_on && !rsp.char_done, "accepted load not keying")
	`MCK_ASSERT_IMP(a_done_idle, rsp_valid && rsp.char_done, !rsp.busy_res && !rsp.led_on,
		"character done while still busy")
	`MCK_ASSERT_IMP(a_led_busy, rsp_valid && rsp.led_on, rsp.busy_res, "LED on while idle")

endmodule

bind morse_character_keyer mck_port_checker u_mck_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

### tb/mck_checker.sv
// Checker for the Morse keyer: predicts every result from the accepted items and compares
module mck_checker
	import mck_pkg::*;
#(
	parameter int MAX_EL = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic                 req_stall,
	input  mck_in_t              req,
	input  logic                 rsp_valid,
	input  logic                 rsp_stall,
	input  mck_out_t             rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]    cfg_wdata,
	output int                   fails,
	output int                   pending,
	output logic                 keying,
	output int                   worked,
	output int                   chars_done,
	output int                   loads_refused
);

	el_t               slots [MAX_EL];
	logic [IDX_W-1:0]  slot_idx;
	key_phase_t        phase;
	logic [TICK_W-1:0] tcount;
	logic              led;
	logic [TICK_W-1:0] dot_len;
	logic [TICK_W-1:0] dash_len;
	logic [TICK_W-1:0] gap_len;
	mck_out_t          results_due [$];
	mck_out_t          want;
	int                n_fail;
	int                n_worked;
	int                n_done;
	int                n_refused;
	int                n_seen;

	function automatic string morse_of(input logic [7:0] c);
		case (c)
			"A": return ".-";     "B": return "-...";   "C": return "-.-.";
			"D": return "-..";    "E": return ".";      "F": return "..-.";
			"G": return "--.";    "H": return "....";   "I": return "..";
			"J": return ".---";   "K": return "-.-";    "L": return ".-..";
			"M": return "--";     "N": return "-.";     "O": return "---";
			"P": return ".--.";   "Q": return "--.-";   "R": return ".-.";
			"S": return "...";    "T": return "-";      "U": return "..-";
			"V": return "...-";   "W": return ".--";    "X": return "-..-";
			"Y": return "-.--";   "Z": return "--..";
			"0": return "-----";  "1": return ".----";  "2": return "..---";
			"3": return "...--";  "4": return "....-";  "5": return ".....";
			"6": return "-....";  "7": return "--...";  "8": return "---..";
			"9": return "----.";
			"?": return "..--.."; "/": return "-..-.";  "(": return "-.--.";
			"-": return "-....-"; ".": return ".-.-.-";
			default: return "";
		endcase
	endfunction

	function automatic void clear_slots();
		for (int i = 0; i < MAX_EL; i++)
			slots[i] = EL_NONE;
	endfunction

	function automatic mck_out_t advance_keyer(input mck_in_t it);
		mck_out_t          r;
		string             pat;
		logic [TICK_W-1:0] span;
		r = '0;
		if (it.cmd == CMD_LOAD) begin
			pat = morse_of(it.char_code);
			if (phase == PH_IDLE && pat.len() != 0) begin
				clear_slots();
				for (int i = 0; i < pat.len() && i < MAX_EL; i++)
					slots[i] = (pat[i] == "-") ? EL_DASH : EL_DOT;
				slot_idx = '0;
				tcount = '0;
				phase = PH_ON;
				led = 1'b1;
				r.accepted = 1'b1;
				n_worked++;
			end else begin
				n_refused++;
			end
		end else if (phase == PH_ON) begin
			n_worked++;
			span = (slot_idx < MAX_EL && slots[slot_idx] == EL_DASH) ? dash_len : dot_len;
			tcount = tcount + 1'b1;
			if (tcount >= span) begin
				tcount = '0;
				phase = PH_GAP;
				led = 1'b0;
			end
		end else if (phase == PH_GAP) begin
			n_worked++;
			tcount = tcount + 1'b1;
			if (tcount >= gap_len) begin
				tcount = '0;
				slot_idx = slot_idx + 1'b1;
				if (slot_idx < MAX_EL && slots[slot_idx] != EL_NONE) begin
					phase = PH_ON;
					led = 1'b1;
				end else begin
					// last gap over: drop the pattern and go idle
					clear_slots();
					slot_idx = '0;
					phase = PH_IDLE;
					led = 1'b0;
					r.char_done = 1'b1;
					n_done++;
				end
			end
		end
		r.led_on = led;
		r.busy_res = (phase != PH_IDLE);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_slots();
			slot_idx = '0;
			phase = PH_IDLE;
			tcount = '0;
			led = 1'b0;
			dot_len = DOT_RESET;
			dash_len = DASH_RESET;
			gap_len = GAP_RESET;
			results_due.delete();
			n_fail = 0;
			n_worked = 0;
			n_done = 0;
			n_refused = 0;
			n_seen = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DOT:  dot_len = cfg_wdata;
					REG_DASH: dash_len = cfg_wdata;
					REG_GAP:  gap_len = cfg_wdata;
					default:  ;
				endcase
			end
			// take the result first: it can never belong to an item accepted at this edge
			if (rsp_valid && !rsp_stall) begin
				n_seen++;
				if (results_due.size() == 0) begin
					n_fail++;
					if (n_fail <= 10)
						$display("Result %0d arrived with nothing expected: %b", n_seen, rsp);
				end else begin
					want = results_due.pop_front();
					if (rsp.led_on !== want.led_on || rsp.busy_res !== want.busy_res ||
							rsp.accepted !== want.accepted || rsp.char_done !== want.char_done) begin
						n_fail++;
						if (n_fail <= 10)
							$display("Result %0d: expected led=%b busy=%b acc=%b done=%b, got led=%b busy=%b acc=%b done=%b",
								n_seen, want.led_on, want.busy_res, want.accepted, want.char_done,
								rsp.led_on, rsp.busy_res, rsp.accepted, rsp.char_done);
					end
				end
			end
			if (req_valid && !req_stall)
				results_due.push_back(advance_keyer(req));
		end
		fails <= n_fail;
		pending <= results_due.size();
		keying <= (phase != PH_IDLE);
		worked <= n_worked;
		chars_done <= n_done;
		loads_refused <= n_refused;
	end

endmodule

### tb/tb.sv
// Testbench top for the Morse keyer: item and register stimulus, receiver stalls and verdict
module tb;
	import mck_pkg::*;

	localparam int ITEMS = 950;
	localparam int LIMIT = 200000;
	localparam int HOLD_CYCLES = 60;
	localparam int SETTLE = 8;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid;
	logic                 req_stall;
	mck_in_t              req;
	logic                 rsp_valid;
	logic                 rsp_stall;
	mck_out_t             rsp;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TICK_W-1:0]    cfg_wdata;

	int   fails;
	int   pending;
	logic keying;
	int   worked;
	int   chars_done;
	int   loads_refused;

	int    cycles = 0;
	int    sent = 0;
	int    settings = 0;
	logic  calm = 1'b0;
	logic  hold_req = 1'b0;
	logic  hold_done = 1'b0;
	string keyable = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789?/(-.";

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	morse_character_keyer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	mck_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.req           (req),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.rsp           (rsp),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.fails         (fails),
		.pending       (pending),
		.keying        (keying),
		.worked        (worked),
		.chars_done    (chars_done),
		.loads_refused (loads_refused)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("Run stopped after %0d cycles with %0d results outstanding", LIMIT, pending);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold-off so the block backs up into its input
	initial begin
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			rsp_stall <= !calm && ($urandom_range(99) < 8);
		end
	end

	task automatic send(input logic op, input logic [7:0] code);
		if (!calm && $urandom_range(99) < 8) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= '{cmd: op, char_code: code};
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sent++;
	endtask

	// drop valid and wait until every expected result has been taken
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic set_timing(input logic [TICK_W-1:0] dot, dash, gap);
		drain();
		write_reg(REG_DOT, dot);
		write_reg(REG_DASH, dash);
		write_reg(REG_GAP, gap);
		write_reg(REG_SPARE, TICK_W'($urandom));
		cfg_we <= 1'b0;
		settings++;
	endtask

	// one character, then ticks until it is keyed out, with the odd load thrown in while busy
	task automatic key_char(input int cap);
		int n;
		if ($urandom_range(9) == 0)
			send(CMD_LOAD, 8'($urandom));
		else
			send(CMD_LOAD, keyable[$urandom_range(0, keyable.len() - 1)]);
		n = 0;
		do begin
			if ($urandom_range(19) == 0)
				send(CMD_LOAD, keyable[$urandom_range(0, keyable.len() - 1)]);
			else
				send(CMD_TICK, 8'($urandom));
			n++;
		end while (keying && n < cap);
	endtask

	initial begin
		int p;
		int chars;
		logic [TICK_W-1:0] dot, dash, gap;
		req_valid <= 1'b0;
		req <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset timing: tick while idle, unknown codes, E, then a load while busy
		send(CMD_TICK, 8'h00);
		send(CMD_LOAD, 8'h00);
		send(CMD_LOAD, 8'hFF);
		send(CMD_LOAD, "E");
		send(CMD_LOAD, "T");
		repeat (2) send(CMD_TICK, 8'hA5);
		// zero lengths while E is still lit: every phase ends on its first tick
		set_timing(16'd0, 16'd0, 16'd0);
		repeat (2) send(CMD_TICK, 8'h5A);
		send(CMD_LOAD, "(");
		repeat (10) send(CMD_TICK, 8'hFF);
		send(CMD_LOAD, "a");
		send(CMD_LOAD, "9");
		repeat (10) send(CMD_TICK, 8'h00);

		p = 0;
		while (sent < ITEMS) begin
			if (p == 0) begin
				set_timing(16'd1, 16'd1, 16'd1);
			end else if (p == 1) begin
				set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
			end else if (p == 2) begin
				// shorter than the count already reached: the current phase ends at once
				set_timing(16'd2, 16'd3, 16'd1);
			end else begin
				dot = ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
				dash = ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
				gap = ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
				set_timing(dot, dash, gap);
			end
			calm = (p == 3);
			if (p == 4)
				hold_req = 1'b1;
			chars = (p == 1) ? 1 : (p == 3) ? 8 : $urandom_range(3, 6);
			repeat (chars) key_char((p == 1) ? 40 : 200);
			p++;
		end

		drain();
		$display("Sent %0d items over %0d register settings, %0d of them moved the keyer on.",
			sent, settings, worked);
		$display("Keyed %0d characters through their last gap; %0d loads were refused.",
			chars_done, loads_refused);
		if (fails == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### morse_character_keyer.f
+incdir+rtl/core
rtl/core/mck_pkg.sv
rtl/core/mck_core.sv
rtl/core/morse_character_keyer.sv
rtl/core/mck_checker.sv
tb/mck_checker.sv
tb/tb.sv
